// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by hall_stall_detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge while reset is released.
`define HSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define HSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/hsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hsd_pkg
// Types and constants of the hall stall detector.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int LEVEL_W     = 16;
  localparam int POS_W       = 24;
  localparam int STEPS_W     = 23;
  localparam int THR_W       = 10;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 23;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  localparam logic [THR_W-1:0]   THR_RST       = 10'd8;
  localparam logic [CNT_W-1:0]   NEED_RST      = 4'd5;
  localparam logic [STEPS_W-1:0] TRAVEL_RST    = 23'd0;
  localparam logic [LEVEL_W-1:0] RANGE_RST     = 16'd150;
  localparam logic [STEPS_W-1:0] STROKE_RST    = 23'd0;
  localparam logic [CNT_W-1:0]   CNT_MAX       = 4'hF;
  localparam logic [LEVEL_W-1:0] LOW_SEEN_RST  = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL_THRESHOLD  = 3'd0,
    REG_STILL_TARGET     = 3'd1,
    REG_MIN_TRAVEL_STEPS = 3'd2,
    REG_SPAN_MIN         = 3'd3,
    REG_FULL_STROKE      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]   stall_threshold;
    logic [CNT_W-1:0]   still_target;
    logic [STEPS_W-1:0] min_travel_steps;
    logic [LEVEL_W-1:0] span_min;
    logic [STEPS_W-1:0] full_stroke;
  } cfg_t;

  typedef struct packed {
    logic               checking;
    logic [LEVEL_W-1:0] change;
    logic [LEVEL_W-1:0] range_seen;
    logic               forced;
    logic               stall_res;
  } result_t;

  typedef struct packed {
    logic             stalled;
    logic [CNT_W-1:0] still_count;
  } status_t;

endpackage

// ----- hw/rtl/hsd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hsd_cfg_regs
// Configuration register bank, write-only, masked to each register width.
// ----------------------------------------------------------------------------
module hsd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output hsd_pkg::cfg_t                    cfg
);

  hsd_pkg::cfg_t cfg_r;
  hsd_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hsd_pkg::reg_idx_t'(cfg_index))
        hsd_pkg::REG_STALL_THRESHOLD:
          cfg_nxt.stall_threshold = cfg_data[hsd_pkg::THR_W-1:0];
        hsd_pkg::REG_STILL_TARGET:
          cfg_nxt.still_target = cfg_data[hsd_pkg::CNT_W-1:0];
        hsd_pkg::REG_MIN_TRAVEL_STEPS:
          cfg_nxt.min_travel_steps = cfg_data[hsd_pkg::STEPS_W-1:0];
        hsd_pkg::REG_SPAN_MIN:
          cfg_nxt.span_min = cfg_data[hsd_pkg::LEVEL_W-1:0];
        hsd_pkg::REG_FULL_STROKE:
          cfg_nxt.full_stroke = cfg_data[hsd_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_threshold  <= hsd_pkg::THR_RST;
      cfg_r.still_target     <= hsd_pkg::NEED_RST;
      cfg_r.min_travel_steps <= hsd_pkg::TRAVEL_RST;
      cfg_r.span_min         <= hsd_pkg::RANGE_RST;
      cfg_r.full_stroke      <= hsd_pkg::STROKE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/hsd_core.sv -----
// ----------------------------------------------------------------------------
// hsd_core
// Run state (range, previous level, still counter, stall latch) and the
// per-sample decision logic.
// ----------------------------------------------------------------------------
module hsd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           start_req,
  input  logic [hsd_pkg::LEVEL_W-1:0]    level,
  input  logic [hsd_pkg::POS_W-1:0]      position,
  input  hsd_pkg::cfg_t                  cfg,
  output hsd_pkg::result_t               res,
  output hsd_pkg::status_t               status
);

  logic [hsd_pkg::LEVEL_W-1:0] prev_level_r, prev_level_nxt;
  logic [hsd_pkg::LEVEL_W-1:0] low_seen_r, low_seen_nxt;
  logic [hsd_pkg::LEVEL_W-1:0] high_seen_r, high_seen_nxt;
  logic [hsd_pkg::CNT_W-1:0]   still_count_r, still_count_nxt;
  logic                        stalled_r, stalled_nxt;

  logic [hsd_pkg::POS_W-1:0]   traveled;
  logic [hsd_pkg::LEVEL_W-1:0] chg;
  logic [hsd_pkg::LEVEL_W-1:0] low_upd;
  logic [hsd_pkg::LEVEL_W-1:0] high_upd;
  logic [hsd_pkg::LEVEL_W-1:0] rng;
  logic [hsd_pkg::CNT_W-1:0]   cnt_inc;
  logic                        active;
  logic                        flat;
  logic                        check;

  always_comb begin
    traveled = position[hsd_pkg::POS_W-1] ? (~position + 1'b1) : position;
    chg      = (level >= prev_level_r) ? (level - prev_level_r) : (prev_level_r - level);
    low_upd  = (level < low_seen_r)  ? level : low_seen_r;
    high_upd = (level > high_seen_r) ? level : high_seen_r;
    rng      = (high_upd >= low_upd) ? (high_upd - low_upd) : '0;
    active   = rng >= cfg.span_min;
    flat     = !active && (traveled >= {1'b0, cfg.full_stroke});
    check    = (traveled >= {1'b0, cfg.min_travel_steps}) && (active || flat);
    cnt_inc  = (still_count_r == hsd_pkg::CNT_MAX) ? still_count_r
                                                   : still_count_r + 1'b1;

    prev_level_nxt  = level;
    low_seen_nxt    = low_upd;
    high_seen_nxt   = high_upd;
    still_count_nxt = still_count_r;
    stalled_nxt     = stalled_r;

    if (start_req) begin
      low_seen_nxt    = hsd_pkg::LOW_SEEN_RST;
      high_seen_nxt   = '0;
      still_count_nxt = '0;
      stalled_nxt     = 1'b0;
    end else if (check && !stalled_r) begin
      if (chg < {{(hsd_pkg::LEVEL_W-hsd_pkg::THR_W){1'b0}}, cfg.stall_threshold}) begin
        still_count_nxt = cnt_inc;
        if (cnt_inc >= cfg.still_target) begin
          stalled_nxt = 1'b1;
        end
      end else begin
        still_count_nxt = '0;
      end
    end

    if (start_req) begin
      res = '0;
    end else begin
      res.stall_res  = stalled_nxt;
      res.forced     = check && flat;
      res.range_seen = rng;
      res.change     = chg;
      res.checking   = check;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r  <= '0;
      low_seen_r    <= hsd_pkg::LOW_SEEN_RST;
      high_seen_r   <= '0;
      still_count_r <= '0;
      stalled_r     <= 1'b0;
    end else if (adv) begin
      prev_level_r  <= prev_level_nxt;
      low_seen_r    <= low_seen_nxt;
      high_seen_r   <= high_seen_nxt;
      still_count_r <= still_count_nxt;
      stalled_r     <= stalled_nxt;
    end
  end

  assign status.stalled     = stalled_r;
  assign status.still_count = still_count_r;

endmodule

// ----- hw/rtl/hall_stall_detector.sv -----
// ----------------------------------------------------------------------------
// hall_stall_detector
// End-stop stall detection from filtered hall samples and step position.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle when both sides keep moving. A sample
// passes through the input register, then the result register, and waits
// in the input register while the result register holds an untaken result.
// The run state updates as a sample leaves the input register, so the next
// sample sees it without a bubble. Send a sample with in_tuser set to begin
// a run; its result is all zeros. Write configuration only while no samples
// are in flight.
`include "assert_macros.svh"

module hall_stall_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [hsd_pkg::IN_DATA_W-1:0]        in_tdata,  // level[15:0], position[39:16]
  input  logic                                 in_tuser,  // start_req
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // stall_res[0], forced[1], range_seen[17:2], change[33:18], checking[34], zero pad
  output logic [hsd_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  logic                                 cfg_we,
  input  logic [hsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int RES_W = $bits(hsd_pkg::result_t);

  hsd_pkg::cfg_t    cfg;
  hsd_pkg::result_t res;
  hsd_pkg::status_t status;

  logic                            in_vld_r;
  logic                            in_start_r;
  logic [hsd_pkg::LEVEL_W-1:0]     in_level_r;
  logic [hsd_pkg::POS_W-1:0]       in_pos_r;
  logic                            out_vld_r;
  logic [hsd_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic                            adv;
  logic                            in_xfer;

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  hsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hsd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .start_req (in_start_r),
    .level     (in_level_r),
    .position  (in_pos_r),
    .cfg       (cfg),
    .res       (res),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_start_r <= in_tuser;
      in_level_r <= in_tdata[hsd_pkg::LEVEL_W-1:0];
      in_pos_r   <= in_tdata[hsd_pkg::LEVEL_W +: hsd_pkg::POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {{(hsd_pkg::OUT_DATA_W-RES_W){1'b0}}, res};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `HSD_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid right after reset")
  `HSD_ASSERT(a_start_zero, adv && in_start_r |=> out_tdata == '0, "start result not all zero")
  `HSD_ASSERT(a_forced_check, out_tvalid && out_tdata[1] |-> out_tdata[34], "forced without checking")
  `HSD_ASSERT(a_stall_latch, status.stalled && !(adv && in_start_r) |=> status.stalled, "stall latch dropped without start")

endmodule
